### rtl/plar_pkg.sv
// Package with types and constants shared by the polyline arc-length resampler.
package plar_pkg;

   localparam int unsigned MAX_RUN_DEFAULT = 64;
   localparam int unsigned CMD_DEPTH       = 2;
   localparam int unsigned RSP_DEPTH       = 2;
   localparam logic [30:0] INTERVAL_RESET  = 31'd16777;

   typedef struct packed {
      logic        start_path;
      logic [31:0] vertex_x;
      logic [31:0] vertex_y;
      logic [31:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_x;
      logic [31:0] sample_y;
      logic [31:0] sample_z;
      logic        last_of_run;
      logic        run_truncated;
   } rsp_type;

   typedef struct packed {
      logic             start_path;
      logic [2:0][31:0] prev;
      logic [2:0][32:0] mag;
      logic [2:0]       neg;
   } cmd_type;

endpackage

### rtl/plar_fifo.sv
// Small first-in first-out queue used between the stages and at the output.
module plar_fifo import plar_pkg::*; #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end
endmodule

### rtl/plar_front.sv
// Front end: accepts vertices, tracks the previous vertex and classifies each transfer.
module plar_front import plar_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  logic    cmd_full
);
   logic             have_prev_ff;
   logic [2:0][31:0] prev_ff;
   logic [2:0][31:0] cur;
   logic [2:0][32:0] diff;
   logic             accept;

   assign cur      = {req_data.vertex_x, req_data.vertex_y, req_data.vertex_z};
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;

   always_comb begin
      cmd_data.start_path = req_data.start_path || !have_prev_ff;
      cmd_data.prev       = prev_ff;
      for (int i = 0; i < 3; i++) begin
         diff[i]          = {cur[i][31], cur[i]} - {prev_ff[i][31], prev_ff[i]};
         cmd_data.neg[i]  = diff[i][32];
         cmd_data.mag[i]  = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
      end else if (accept) begin
         have_prev_ff <= 1'b1;
         prev_ff      <= cur;
      end
   end
endmodule

### rtl/plar_back.sv
// Back end: segment length, sample count and interpolation of every sample.
module plar_back import plar_pkg::*; #(
   parameter int unsigned MAX_RUN = MAX_RUN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [30:0] interval,
   input  logic        cmd_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   input  logic        rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp_data
);
   localparam int unsigned KW = $clog2(MAX_RUN + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_LO, S_MUL_HI, S_MUL_ADD, S_SUM, S_SQRT, S_CHECK,
      S_DIV, S_PLAN, S_SDIV, S_OUT
   } state_type;

   state_type        state_ff;
   logic             sq_ff;
   logic [2:0][31:0] prev_ff;
   logic [2:0][32:0] mag_ff;
   logic [2:0]       neg_ff;
   logic [2:0][49:0] prod_ff;
   logic [2:0][66:0] acc_ff;
   logic [2:0][34:0] qrem_ff;
   logic [65:0]      rad_ff;
   logic [35:0]      srem_ff;
   logic [32:0]      len_ff;
   logic [5:0]       it_ff;
   logic [31:0]      dist_ff;
   logic [32:0]      dk_ff;
   logic [32:0]      dnum_ff;
   logic [31:0]      drem_ff;
   logic [KW-1:0]    n_ff, k_ff;
   logic             trunc_ff;

   logic [30:0]      ival;
   logic [2:0][49:0] mul_in;
   logic [2:0][32:0] bop;
   logic [2:0][66:0] acc_sum;
   logic [35:0]      sq_rem, sq_trial;
   logic [31:0]      dv_rem;
   logic [2:0][34:0] sd_rem;
   logic [2:0][31:0] smp;
   logic             last_in;

   assign ival = (interval == '0) ? 31'd1 : interval;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bop[i]    = sq_ff ? mag_ff[i] : dk_ff;
         mul_in[i] = mag_ff[i] * ((state_ff == S_MUL_LO) ? {1'b0, bop[i][15:0]} & 17'h0ffff
                                   | {16'b0, bop[i][16]} << 16
                                 : {1'b0, bop[i][32:17]});
         acc_sum[i] = acc_ff[i] + (67'(prod_ff[i]) << 17)
                      + (sq_ff ? 67'd0 : 67'(len_ff[32:1]));
         sd_rem[i] = {qrem_ff[i][33:0], acc_ff[i][32]};
         smp[i]    = neg_ff[i] ? prev_ff[i] - acc_ff[i][31:0] : prev_ff[i] + acc_ff[i][31:0];
      end
      sq_rem   = {srem_ff[33:0], rad_ff[65:64]};
      sq_trial = {1'b0, len_ff, 2'b01};
      dv_rem   = {drem_ff[30:0], dnum_ff[32]};
      last_in  = ((k_ff + KW'(1)) == n_ff);
   end

   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff == S_OUT) && !rsp_full;
   assign rsp_data = '{sample_x: smp[2], sample_y: smp[1], sample_z: smp[0],
                       last_of_run: last_in, run_truncated: trunc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dist_ff  <= {1'b0, INTERVAL_RESET};
         sq_ff    <= 1'b0;
         it_ff    <= '0;
         k_ff     <= '0;
         n_ff     <= '0;
         trunc_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  if (cmd_data.start_path) begin
                     dist_ff <= {1'b0, ival};
                  end else begin
                     prev_ff  <= cmd_data.prev;
                     mag_ff   <= cmd_data.mag;
                     neg_ff   <= cmd_data.neg;
                     sq_ff    <= 1'b1;
                     state_ff <= S_MUL_LO;
                  end
               end
            end
            S_MUL_LO: begin
               prod_ff  <= mul_in;
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               for (int i = 0; i < 3; i++) begin
                  acc_ff[i] <= 67'(prod_ff[i]);
               end
               prod_ff  <= mul_in;
               state_ff <= S_MUL_ADD;
            end
            S_MUL_ADD: begin
               for (int i = 0; i < 3; i++) begin
                  acc_ff[i] <= acc_sum[i];
               end
               it_ff    <= '0;
               state_ff <= sq_ff ? S_SUM : S_SDIV;
               if (!sq_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     qrem_ff[i] <= {1'b0, acc_sum[i][66:33]};
                  end
               end
            end
            S_SUM: begin
               rad_ff   <= 66'(acc_ff[0] + acc_ff[1] + acc_ff[2]);
               srem_ff  <= '0;
               len_ff   <= '0;
               it_ff    <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               rad_ff <= {rad_ff[63:0], 2'b00};
               if (sq_rem >= sq_trial) begin
                  srem_ff <= sq_rem - sq_trial;
                  len_ff  <= {len_ff[31:0], 1'b1};
               end else begin
                  srem_ff <= sq_rem;
                  len_ff  <= {len_ff[31:0], 1'b0};
               end
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'd32) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if ({1'b0, dist_ff} > len_ff) begin
                  dist_ff  <= dist_ff - len_ff[31:0];
                  state_ff <= S_IDLE;
               end else begin
                  dnum_ff  <= len_ff - {1'b0, dist_ff};
                  drem_ff  <= '0;
                  it_ff    <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (dv_rem >= {1'b0, ival}) begin
                  drem_ff <= dv_rem - {1'b0, ival};
                  dnum_ff <= {dnum_ff[31:0], 1'b1};
               end else begin
                  drem_ff <= dv_rem;
                  dnum_ff <= {dnum_ff[31:0], 1'b0};
               end
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'd32) begin
                  state_ff <= S_PLAN;
               end
            end
            S_PLAN: begin
               trunc_ff <= (dnum_ff >= 33'(MAX_RUN));
               n_ff     <= (dnum_ff >= 33'(MAX_RUN)) ? KW'(MAX_RUN)
                                                      : KW'(dnum_ff) + KW'(1);
               k_ff     <= '0;
               dk_ff    <= {1'b0, dist_ff};
               dist_ff  <= {1'b0, ival} - drem_ff;
               sq_ff    <= 1'b0;
               state_ff <= S_MUL_LO;
            end
            S_SDIV: begin
               for (int i = 0; i < 3; i++) begin
                  if (sd_rem[i] >= {2'b00, len_ff}) begin
                     qrem_ff[i] <= sd_rem[i] - {2'b00, len_ff};
                     acc_ff[i]  <= {acc_ff[i][65:0], 1'b1};
                  end else begin
                     qrem_ff[i] <= sd_rem[i];
                     acc_ff[i]  <= {acc_ff[i][65:0], 1'b0};
                  end
               end
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'd32) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_full) begin
                  if (last_in) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + KW'(1);
                     dk_ff    <= dk_ff + {2'b00, ival};
                     state_ff <= S_MUL_LO;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

### rtl/polyline_arc_length_resampler_top.sv
// Top level of the polyline arc-length resampler.
// A path-start vertex only resets the pending distance in the back end; a segment with no sample
// passes the multiply, sum, square root and check states. The first sample of a segment enters
// the output queue after the 33-step square root, the 33-step interval division and the 33-step
// per-sample division (three lanes); each further sample repeats the multiply and per-sample division.
// Reset is synchronous: the interval returns to 16777 and no previous vertex is held.
module polyline_arc_length_resampler_top import plar_pkg::*; #(
   parameter int unsigned MAX_RUN = MAX_RUN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);
   logic [30:0] interval_ff;
   logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type     cmd_wdata, cmd_rdata;
   logic        rsp_push, rsp_full;
   rsp_type     rsp_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_we) begin
         interval_ff <= csr_wdata;
      end
   end

   plar_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata),
      .cmd_full (cmd_full)
   );

   plar_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   plar_back #(.MAX_RUN(MAX_RUN)) u_back (
      .clock     (clock),
      .reset     (reset),
      .interval  (interval_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   plar_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );
endmodule

### rtl/plar_checker.sv
// Port-level checker for the resampler, bound to the top level.
module plar_checker import plar_pkg::*; #(
   parameter int unsigned MAX_RUN = MAX_RUN_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);
   localparam int unsigned KW = $clog2(MAX_RUN + 1);

   logic [KW-1:0] run_cnt_ff;
   logic          out_xfer;

   assign out_xfer = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else if (out_xfer) begin
         run_cnt_ff <= rsp_data.last_of_run ? '0 : run_cnt_ff + KW'(1);
      end
   end

   a_reset_clean: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      out_xfer && !rsp_data.last_of_run |-> run_cnt_ff < KW'(MAX_RUN - 1))
      else $error("run longer than the limit");

   a_trunc_len: assert property (@(posedge clock) disable iff (reset)
      out_xfer && rsp_data.last_of_run && rsp_data.run_truncated
      |-> run_cnt_ff == KW'(MAX_RUN - 1))
      else $error("truncated run has wrong length");
endmodule

bind polyline_arc_length_resampler_top plar_checker #(.MAX_RUN(MAX_RUN)) u_checker (.*);

### test/tb_polyline_arc_length_resampler_top.sv
// Self-checking testbench for the polyline arc-length resampler top level.
module tb_polyline_arc_length_resampler_top;
   import plar_pkg::*;

   localparam int RUN_LIMIT = 64;

   class resample_scoreboard;
      logic [30:0]        interval;
      logic signed [63:0] px, py, pz;
      logic [63:0]        dist_left;
      bit                 have_prev;
      rsp_type            pending[$];
      int                 errors;

      function new();
         interval  = INTERVAL_RESET;
         px = 0; py = 0; pz = 0;
         dist_left = INTERVAL_RESET;
         have_prev = 0;
         errors    = 0;
      endfunction

      function logic [63:0] root66(logic [65:0] v);
         logic [65:0] rem, trial;
         logic [65:0] root;
         rem = 0; root = 0;
         for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 66'd3);
            trial = (root << 2) | 66'd1;
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 66'd1;
            end else begin
               root = root << 1;
            end
         end
         return root[63:0];
      endfunction

      function logic [31:0] interp(logic signed [63:0] p, logic signed [63:0] c,
                                   logic [63:0] d, logic [63:0] len);
         logic signed [63:0] diff;
         logic [127:0]       m, q;
         diff = c - p;
         m = (diff < 0) ? -diff : diff;
         q = (m * {64'd0, d} + {64'd0, len >> 1}) / {64'd0, len};
         return (diff < 0) ? 32'(p - 64'(q)) : 32'(p + 64'(q));
      endfunction

      function void note_vertex(req_type r);
         logic [63:0]        ival, len, d, due, n;
         logic signed [63:0] cx, cy, cz;
         logic [63:0]        ax, ay, az;
         logic [65:0]        ss;
         rsp_type            s;
         ival = (interval == 0) ? 64'd1 : {33'd0, interval};
         cx = 64'(signed'(r.vertex_x));
         cy = 64'(signed'(r.vertex_y));
         cz = 64'(signed'(r.vertex_z));
         if (r.start_path || !have_prev) begin
            px = cx; py = cy; pz = cz;
            dist_left = ival;
            have_prev = 1;
            return;
         end
         ax = (cx - px < 0) ? px - cx : cx - px;
         ay = (cy - py < 0) ? py - cy : cy - py;
         az = (cz - pz < 0) ? pz - cz : cz - pz;
         ss = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
         len = root66(ss);
         d = dist_left;
         due = (d <= len) ? (len - d) / ival + 1 : 0;
         n = (due > RUN_LIMIT) ? RUN_LIMIT : due;
         for (int k = 0; k < n; k++) begin
            s.sample_x      = interp(px, cx, d, len);
            s.sample_y      = interp(py, cy, d, len);
            s.sample_z      = interp(pz, cz, d, len);
            s.last_of_run   = (k + 1 == n);
            s.run_truncated = (due > RUN_LIMIT);
            pending = {pending, s};
            d = d + ival;
         end
         if (due == 0) dist_left = dist_left - len;
         else dist_left = ival - ((len - dist_left) % ival);
         px = cx; py = cy; pz = cz;
      endfunction

      function void check_sample(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected sample %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.sample_x !== e.sample_x) begin
            $error("sample_x exp %h got %h", e.sample_x, a.sample_x); errors++;
         end
         if (a.sample_y !== e.sample_y) begin
            $error("sample_y exp %h got %h", e.sample_y, a.sample_y); errors++;
         end
         if (a.sample_z !== e.sample_z) begin
            $error("sample_z exp %h got %h", e.sample_z, a.sample_z); errors++;
         end
         if (a.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %b got %b", e.last_of_run, a.last_of_run); errors++;
         end
         if (a.run_truncated !== e.run_truncated) begin
            $error("run_truncated exp %b got %b", e.run_truncated, a.run_truncated);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [30:0] csr_wdata = '0;

   resample_scoreboard board = new();
   int          cycle_count = 0;
   int          hold_cycles = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;
   bit          stall_mode = 0;

   polyline_arc_length_resampler_top DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("tb_polyline_arc_length_resampler_top NOT OK");
         $finish;
      end
   end

   // The receiver samples the transfer, then picks its next pop.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) board.check_sample(rsp_data);
         if (hold_req && !hold_done) begin
            hold_done   <= 1;
            hold_cycles <= 3000;
            rsp_pop     <= 0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop <= 0;
         end else if (stall_mode) begin
            rsp_pop <= ($urandom_range(0, 3) == 0);
         end else begin
            rsp_pop <= ($urandom_range(0, 7) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ($urandom_range(0, 200) == 0)) stall_mode <= ~stall_mode;
   end

   task automatic send_vertex(req_type r);
      req_push <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_vertex(r);
   endtask

   task automatic idle_cycles(int g);
      if (g > 0) begin
         req_push <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic idle_gap();
      idle_cycles($urandom_range(0, 6));
   endtask

   task automatic drain_and_set(logic [30:0] v);
      req_push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.interval = v;
   endtask

   function automatic req_type vtx(bit sp, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type r;
      r.start_path = sp; r.vertex_x = x; r.vertex_y = y; r.vertex_z = z;
      return r;
   endfunction

   function automatic logic [31:0] near(logic [31:0] base, int span);
      return base + 32'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic random_path(int verts, int span);
      logic [31:0] x, y, z;
      x = $urandom; y = $urandom; z = $urandom;
      send_vertex(vtx(1, x, y, z));
      for (int i = 0; i < verts; i++) begin
         idle_gap();
         if ($urandom_range(0, 15) == 0) begin
            x = $urandom; y = $urandom; z = $urandom;
         end else begin
            x = near(x, span); y = near(y, span); z = near(z, span);
         end
         send_vertex(vtx($urandom_range(0, 20) == 0, x, y, z));
      end
   endtask

   initial begin
      int burst;
      logic [30:0] settings[4];
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at the reset interval, then at extremes.
      send_vertex(vtx(0, 32'd0, 32'd0, 32'd0));
      send_vertex(vtx(0, 32'd100000, 32'd0, 32'd0));
      send_vertex(vtx(0, 32'd100000, 32'd0, 32'd0));
      send_vertex(vtx(0, 32'd50000, 32'd30000, 32'hFFFF_0000));
      send_vertex(vtx(0, 32'd1600000, 32'd0, 32'd0));
      send_vertex(vtx(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_vertex(vtx(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      drain_and_set(31'd0);
      send_vertex(vtx(1, 32'd0, 32'd0, 32'd0));
      send_vertex(vtx(0, 32'd70, 32'hFFFF_FFC0, 32'd5));
      send_vertex(vtx(0, 32'd70, 32'hFFFF_FFC0, 32'd5));
      drain_and_set(31'h7FFF_FFFF);
      send_vertex(vtx(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_vertex(vtx(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_vertex(vtx(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      drain_and_set(31'd1000);
      send_vertex(vtx(1, 32'd0, 32'd0, 32'd0));
      send_vertex(vtx(0, 32'd3000, 32'd4000, 32'd0));
      // Interval change with a distance pending.
      drain_and_set(31'd777);
      send_vertex(vtx(0, 32'd3000, 32'd4000, 32'd9000));

      // Long receiver hold-off while the sender keeps offering.
      drain_and_set(31'd200);
      hold_req = 1;
      send_vertex(vtx(1, 32'd0, 32'd0, 32'd0));
      for (int i = 1; i <= 6; i++) send_vertex(vtx(0, 32'(i * 3000), 32'd0, 32'd0));

      settings[0] = 31'd300; settings[1] = 31'd16777;
      settings[2] = 31'd1;   settings[3] = 31'h0100_0000;
      for (int ph = 0; ph < 8; ph++) begin
         drain_and_set(settings[ph % 4]);
         burst = 0;
         while (burst < 40) begin
            case (ph % 4)
               0: random_path(7, 2000);
               1: random_path(7, 50000);
               2: random_path(7, 20);
               default: random_path(7, 32'h0800_0000);
            endcase
            burst += 8;
            idle_cycles($urandom_range(0, 30));
         end
      end

      req_push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_polyline_arc_length_resampler_top OK");
      end else begin
         $display("tb_polyline_arc_length_resampler_top NOT OK");
      end
      $finish;
   end
endmodule
